// ===== hdl/ordered_sequence_table_unit_macros.svh =====
// assertion macros for the ordered sequence table unit
// expects clk and rst in the scope of the module that uses them
`ifndef ORDERED_SEQUENCE_TABLE_UNIT_MACROS_SVH
`define ORDERED_SEQUENCE_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define OST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered sequence table check failed");

// next-cycle implication
`define OST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered sequence table check failed");

`endif

// ===== hdl/ost_pkg.sv =====
// shared constants and types for the ordered sequence table unit
// no dependencies
package ost_pkg;

  localparam int OP_W      = 3;
  localparam int POS_W     = 9;
  localparam int VAL_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int IDX_W     = 8;
  localparam int CNT_OUT_W = 9;

  localparam int DEF_CAPACITY    = 256;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic [OP_W-1:0] OP_INSERT_AT     = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT_SORTED = 3'd1;
  localparam logic [OP_W-1:0] OP_ERASE         = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_ALL    = 3'd3;
  localparam logic [OP_W-1:0] OP_GET           = 3'd4;
  localparam logic [OP_W-1:0] OP_SET           = 3'd5;
  localparam logic [OP_W-1:0] OP_FIND          = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef struct packed {
    logic eq;
    logic le;
  } cmp_res_t;

endpackage

// ===== hdl/ost_mem.sv =====
// item storage: one write port, one read port with registered read data
// depends on ost_pkg for the port control struct
module ost_mem #(
  parameter int DEPTH = ost_pkg::DEF_CAPACITY,
  parameter int WIDTH = ost_pkg::DEF_VALUE_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  ost_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      store[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= store[raddr];
    end
  end

endmodule

// ===== hdl/ost_cmp.sv =====
// shared compare unit: equality and unsigned less-or-equal of key against item
// depends on ost_pkg for the result struct
module ost_cmp #(
  parameter int WIDTH = ost_pkg::DEF_VALUE_WIDTH
) (
  input  logic [WIDTH-1:0] key,
  input  logic [WIDTH-1:0] item,
  output ost_pkg::cmp_res_t res
);

  assign res.eq = (key == item);
  assign res.le = (key <= item);

endmodule

// ===== hdl/ost_ctrl.sv =====
// sequencer: decodes a transaction, streams the list through the memory and
// the compare unit, and holds the result register; depends on ost_pkg
`include "ordered_sequence_table_unit_macros.svh"

module ost_ctrl #(
  parameter int CAPACITY    = ost_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = ost_pkg::DEF_VALUE_WIDTH,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [ost_pkg::OP_W-1:0]      operation,
  input  logic [ost_pkg::POS_W-1:0]     position,
  input  logic [ost_pkg::VAL_W-1:0]     item_value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [ost_pkg::STATUS_W-1:0]  status,
  output logic [ost_pkg::IDX_W-1:0]     result_index,
  output logic [ost_pkg::VAL_W-1:0]     read_value,
  output logic [ost_pkg::CNT_OUT_W-1:0] removed_count,
  output logic [ost_pkg::CNT_OUT_W-1:0] size_now,
  output logic                          is_empty,
  output ost_pkg::mem_ctl_t             mem_ctl,
  output logic [AW-1:0]                 mem_waddr,
  output logic [VALUE_WIDTH-1:0]        mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [VALUE_WIDTH-1:0]        mem_rdata,
  output logic [VALUE_WIDTH-1:0]        key,
  input  ost_pkg::cmp_res_t             cmp_res
);

  import ost_pkg::*;

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]             state;
  logic [OP_W-1:0]        op;
  logic [AW-1:0]          start;
  logic [CW-1:0]          ra;
  logic [CW-1:0]          lim;
  logic                   dv;
  logic [AW-1:0]          da;
  logic                   found;
  logic [VALUE_WIDTH-1:0] carry;
  logic [CW-1:0]          w;
  logic [CW-1:0]          removed;
  logic [AW-1:0]          idx;
  logic [VALUE_WIDTH-1:0] readv;
  logic [STATUS_W-1:0]    stat;
  logic [CW-1:0]          count;

  logic                   accept;
  logic [PW-1:0]          posw;
  logic [PW-1:0]          cntw;
  logic                   pos_gt;
  logic                   pos_ge;
  logic                   full;
  logic [VALUE_WIDTH-1:0] key_in;
  logic                   issue;
  logic                   scan_end;
  logic                   is_ins;
  logic                   is_cmp;
  logic                   hit;
  logic                   drop;
  logic                   deliver;

  logic [1:0]             state_init;
  logic [STATUS_W-1:0]    stat_init;
  logic [CW-1:0]          ra_init;
  logic [CW-1:0]          lim_init;
  logic [CW-1:0]          w_init;
  logic                   found_init;
  logic [AW-1:0]          idx_init;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign posw      = PW'(position);
  assign cntw      = PW'(count);
  assign pos_gt    = (posw > cntw);
  assign pos_ge    = (posw >= cntw);
  assign full      = (count == CW'(CAPACITY));
  assign key_in    = VALUE_WIDTH'(item_value);

  assign issue     = (state == S_SCAN) && (ra < lim);
  assign scan_end  = (state == S_SCAN) && !dv && !issue;
  assign is_ins    = (op == OP_INSERT_AT) || (op == OP_INSERT_SORTED);
  assign is_cmp    = (op == OP_ERASE) || (op == OP_REMOVE_ALL);
  assign hit       = found || cmp_res.le;
  assign drop      = (op == OP_ERASE) ? (da == start) : cmp_res.eq;
  assign deliver   = (state == S_DONE) && !(rsp_valid && rsp_stall);

  assign mem_raddr  = AW'(ra);

  // decode of an accepted transaction
  always_comb begin
    state_init = S_SCAN;
    stat_init  = ST_OK;
    ra_init    = '0;
    lim_init   = count;
    w_init     = '0;
    found_init = 1'b0;
    idx_init   = '0;
    case (operation)
      OP_INSERT_AT: begin
        if (pos_gt) begin
          stat_init  = ST_BAD_POS;
          state_init = S_DONE;
        end else if (full) begin
          stat_init  = ST_FULL;
          state_init = S_DONE;
        end else begin
          ra_init    = CW'(position);
          found_init = 1'b1;
          idx_init   = AW'(position);
        end
      end
      OP_INSERT_SORTED: begin
        if (full) begin
          stat_init  = ST_FULL;
          state_init = S_DONE;
        end
      end
      OP_ERASE: begin
        if (pos_ge) begin
          stat_init  = ST_BAD_POS;
          state_init = S_DONE;
        end else begin
          ra_init = CW'(position);
          w_init  = CW'(position);
        end
      end
      OP_REMOVE_ALL: begin
      end
      OP_GET: begin
        if (pos_ge) begin
          stat_init  = ST_BAD_POS;
          state_init = S_DONE;
        end else begin
          ra_init  = CW'(position);
          lim_init = CW'(posw + PW'(1));
        end
      end
      OP_SET: begin
        if (pos_ge) begin
          stat_init = ST_BAD_POS;
        end
        state_init = S_DONE;
      end
      OP_FIND: begin
        stat_init = ST_NOT_FOUND;
      end
      default: begin
        state_init = S_DONE;
      end
    endcase
  end

  always_comb begin
    mem_ctl.re = issue;
    mem_ctl.we = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    if (accept && (operation == OP_SET) && !pos_ge) begin
      mem_ctl.we = 1'b1;
      mem_waddr  = AW'(position);
      mem_wdata  = key_in;
    end else if (state == S_SCAN) begin
      if (dv) begin
        if (is_ins && hit) begin
          mem_ctl.we = 1'b1;
          mem_waddr  = da;
          mem_wdata  = carry;
        end else if (is_cmp && !drop) begin
          mem_ctl.we = 1'b1;
          mem_waddr  = AW'(w);
          mem_wdata  = mem_rdata;
        end
      end else if (scan_end && is_ins) begin
        mem_ctl.we = 1'b1;
        mem_waddr  = AW'(count);
        mem_wdata  = carry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      dv        <= 1'b0;
    end else begin
      if (deliver) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      dv <= issue;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op      <= operation;
            key     <= key_in;
            carry   <= key_in;
            stat    <= stat_init;
            idx     <= idx_init;
            readv   <= '0;
            removed <= '0;
            found   <= found_init;
            ra      <= ra_init;
            lim     <= lim_init;
            w       <= w_init;
            start   <= AW'(position);
            state   <= state_init;
          end
        end
        S_SCAN: begin
          da <= AW'(ra);
          if (issue) begin
            ra <= ra + CW'(1);
          end
          if (dv) begin
            case (op)
              OP_INSERT_AT, OP_INSERT_SORTED: begin
                if (hit) begin
                  carry <= mem_rdata;
                  found <= 1'b1;
                  if (!found) begin
                    idx <= da;
                  end
                end
              end
              OP_ERASE, OP_REMOVE_ALL: begin
                if (drop) begin
                  removed <= removed + CW'(1);
                end else begin
                  w <= w + CW'(1);
                end
              end
              OP_GET: begin
                readv <= mem_rdata;
              end
              OP_FIND: begin
                if (cmp_res.eq) begin
                  stat  <= ST_OK;
                  idx   <= da;
                  state <= S_DONE;
                end
              end
              default: begin
              end
            endcase
          end
          if (scan_end) begin
            if (is_ins) begin
              count <= count + CW'(1);
              if (!found) begin
                idx <= AW'(count);
              end
            end else if (is_cmp) begin
              count <= w;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (deliver) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (deliver) begin
      status        <= stat;
      result_index  <= IDX_W'(idx);
      read_value    <= VAL_W'(readv);
      removed_count <= (op == OP_REMOVE_ALL) ? CNT_OUT_W'(removed) : '0;
      size_now      <= CNT_OUT_W'(count);
      is_empty      <= (count == '0);
    end
  end

  `OST_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(CAPACITY))
  `OST_ASSERT_IMP(a_write_in_list, mem_ctl.we, CW'(mem_waddr) <= count)
  `OST_ASSERT_NXT(a_accept_leaves_idle, accept, state != S_IDLE)
  `OST_ASSERT_NXT(a_done_delivers, deliver, rsp_valid && (state == S_IDLE))

endmodule

// ===== hdl/ordered_sequence_table_unit.sv =====
// ordered sequence table unit: top level with sequencer, compare unit and item memory
// depends on ost_pkg, ost_mem, ost_cmp, ost_ctrl
//
//  channel   handshake             payload
//  request   req_valid / req_stall operation, position, item_value
//  result    rsp_valid / rsp_stall status, result_index, read_value,
//                                  removed_count, size_now, is_empty
//
// one transaction at a time; n list entries stream through the memory read port,
// one entry a cycle; a scan covers at most CAPACITY entries
// get reads a single entry; set and rejected transactions skip the scan
// reset empties the table at once; item memory is left as is
// req_stall is high while a transaction is in progress
// a result held by rsp_stall does not block the next request, only its completion
module ordered_sequence_table_unit #(
  parameter int CAPACITY    = ost_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = ost_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [ost_pkg::OP_W-1:0]      operation,
  input  logic [ost_pkg::POS_W-1:0]     position,
  input  logic [ost_pkg::VAL_W-1:0]     item_value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [ost_pkg::STATUS_W-1:0]  status,
  output logic [ost_pkg::IDX_W-1:0]     result_index,
  output logic [ost_pkg::VAL_W-1:0]     read_value,
  output logic [ost_pkg::CNT_OUT_W-1:0] removed_count,
  output logic [ost_pkg::CNT_OUT_W-1:0] size_now,
  output logic                          is_empty
);

  import ost_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  mem_ctl_t               mem_ctl;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic [VALUE_WIDTH-1:0] key;
  cmp_res_t               cmp_res;

  ost_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .operation     (operation),
    .position      (position),
    .item_value    (item_value),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .result_index  (result_index),
    .read_value    (read_value),
    .removed_count (removed_count),
    .size_now      (size_now),
    .is_empty      (is_empty),
    .mem_ctl       (mem_ctl),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .key           (key),
    .cmp_res       (cmp_res)
  );

  ost_cmp #(
    .WIDTH (VALUE_WIDTH)
  ) u_cmp (
    .key  (key),
    .item (mem_rdata),
    .res  (cmp_res)
  );

  ost_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== tb/ordered_sequence_table_checker.sv =====
// checker for the ordered sequence table unit: watches both channels, keeps its own copy
// of the list, predicts every result and compares it field by field
// depends on ost_pkg
module ordered_sequence_table_checker #(
  parameter int CAPACITY = ost_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  logic [ost_pkg::OP_W-1:0]      operation,
  input  logic [ost_pkg::POS_W-1:0]     position,
  input  logic [ost_pkg::VAL_W-1:0]     item_value,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  logic [ost_pkg::STATUS_W-1:0]  status,
  input  logic [ost_pkg::IDX_W-1:0]     result_index,
  input  logic [ost_pkg::VAL_W-1:0]     read_value,
  input  logic [ost_pkg::CNT_OUT_W-1:0] removed_count,
  input  logic [ost_pkg::CNT_OUT_W-1:0] size_now,
  input  logic                          is_empty,
  output int                            error_count,
  output int                            waiting,
  output int                            fill_level,
  output int                            peak_fill,
  output int                            results_checked,
  output int                            full_rejects
);
  timeunit 1ns;
  timeprecision 1ps;
  import ost_pkg::*;

  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [STATUS_W-1:0]  status;
    logic [IDX_W-1:0]     slot;
    logic [VAL_W-1:0]     rdata;
    logic [CNT_OUT_W-1:0] removed;
    logic [CNT_OUT_W-1:0] fill;
    logic                 empty;
  } table_outcome_t;

  logic [VAL_W-1:0] entries [CAPACITY];
  int               held;
  table_outcome_t   expected_results [$];

  function automatic void shift_in(input int at, input logic [VAL_W-1:0] val);
    int k;
    for (k = held; k > at; k--) entries[k] = entries[k-1];
    entries[at] = val;
    held++;
  endfunction

  function automatic table_outcome_t apply_table_op(input logic [OP_W-1:0] op,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [VAL_W-1:0] val);
    table_outcome_t r;
    int k;
    int w;
    int removed;
    r = '0;
    r.op = op;
    r.status = ST_OK;
    case (op)
      OP_INSERT_AT: begin
        if (pos > held) begin
          r.status = ST_BAD_POS;
        end else if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shift_in(pos, val);
          r.slot = pos[IDX_W-1:0];
        end
      end
      OP_INSERT_SORTED: begin
        if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (k = 0; k < held; k++) begin
            if (val <= entries[k]) break;
          end
          shift_in(k, val);
          r.slot = k[IDX_W-1:0];
        end
      end
      OP_ERASE: begin
        if (pos >= held) begin
          r.status = ST_BAD_POS;
        end else begin
          for (k = pos; k + 1 < held; k++) entries[k] = entries[k+1];
          held--;
        end
      end
      OP_REMOVE_ALL: begin
        w = 0;
        removed = 0;
        for (k = 0; k < held; k++) begin
          if (entries[k] == val) begin
            removed++;
          end else begin
            entries[w] = entries[k];
            w++;
          end
        end
        held = w;
        r.removed = removed[CNT_OUT_W-1:0];
      end
      OP_GET: begin
        if (pos >= held) r.status = ST_BAD_POS;
        else r.rdata = entries[pos];
      end
      OP_SET: begin
        if (pos >= held) r.status = ST_BAD_POS;
        else entries[pos] = val;
      end
      OP_FIND: begin
        r.status = ST_NOT_FOUND;
        for (k = 0; k < held; k++) begin
          if (entries[k] == val) begin
            r.status = ST_OK;
            r.slot = k[IDX_W-1:0];
            break;
          end
        end
      end
      default: begin
      end
    endcase
    r.fill = held[CNT_OUT_W-1:0];
    r.empty = (held == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
    error_count = error_count + 1;
  endtask

  task automatic check_field(input string name, input logic [OP_W-1:0] op,
                             input logic [VAL_W-1:0] got, input logic [VAL_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s after op %0d: got %0h, expected %0h", name, op, got, want));
    end
  endtask

  always @(posedge clk) begin : track
    table_outcome_t want;
    if (rst) begin
      held = 0;
      expected_results.delete();
      waiting <= 0;
      fill_level <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result transaction with nothing outstanding, status %0d",
                                    status));
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.op, VAL_W'(status), VAL_W'(want.status));
          check_field("result index", want.op, VAL_W'(result_index), VAL_W'(want.slot));
          check_field("read value", want.op, read_value, want.rdata);
          check_field("removed count", want.op, VAL_W'(removed_count), VAL_W'(want.removed));
          check_field("size", want.op, VAL_W'(size_now), VAL_W'(want.fill));
          check_field("empty flag", want.op, VAL_W'(is_empty), VAL_W'(want.empty));
          results_checked <= results_checked + 1;
        end
      end
      if (req_valid && !req_stall) begin
        want = apply_table_op(operation, position, item_value);
        expected_results.push_back(want);
        if (want.status == ST_FULL) full_rejects <= full_rejects + 1;
      end
      waiting <= expected_results.size();
      fill_level <= held;
      if (held > peak_fill) peak_fill <= held;
    end
  end

endmodule

// ===== tb/ordered_sequence_table_unit_test.sv =====
// testbench top for ordered_sequence_table_unit: clock, reset, request stimulus,
// result stall and verdict; checking lives in ordered_sequence_table_checker
// depends on ost_pkg, ordered_sequence_table_unit and ordered_sequence_table_checker
module ordered_sequence_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ost_pkg::*;

  localparam int HALF_PERIOD      = 5;
  localparam int RESET_CYCLES     = 8;
  localparam int CAPACITY         = DEF_CAPACITY;
  localparam int POS_MAX          = (1 << POS_W) - 1;
  localparam int NUM_COMMON       = 8;
  localparam int ITEM_TOTAL       = 840;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES      = CAPACITY + 40;
  localparam int WATCHDOG_LIMIT   = 5000;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic [OP_W-1:0]      operation = OP_GET;
  logic [POS_W-1:0]     position = '0;
  logic [VAL_W-1:0]     item_value = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [IDX_W-1:0]     result_index;
  logic [VAL_W-1:0]     read_value;
  logic [CNT_OUT_W-1:0] removed_count;
  logic [CNT_OUT_W-1:0] size_now;
  logic                 is_empty;

  int error_count;
  int waiting;
  int fill_level;
  int peak_fill;
  int results_checked;
  int full_rejects;

  int   items_sent = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic long_hold = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cycles = 0;
  int   quiet_cycles = 0;

  ordered_sequence_table_unit #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VAL_W)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .operation     (operation),
    .position      (position),
    .item_value    (item_value),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .result_index  (result_index),
    .read_value    (read_value),
    .removed_count (removed_count),
    .size_now      (size_now),
    .is_empty      (is_empty)
  );

  ordered_sequence_table_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .operation       (operation),
    .position        (position),
    .item_value      (item_value),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .result_index    (result_index),
    .read_value      (read_value),
    .removed_count   (removed_count),
    .size_now        (size_now),
    .is_empty        (is_empty),
    .error_count     (error_count),
    .waiting         (waiting),
    .fill_level      (fill_level),
    .peak_fill       (peak_fill),
    .results_checked (results_checked),
    .full_rejects    (full_rejects)
  );

  always #HALF_PERIOD clk = ~clk;

  // result side: random stall, or one long hold counted here
  always @(posedge clk) begin
    if (long_hold && !hold_done) begin
      rsp_stall <= 1'b1;
      if (hold_cycles == LONG_HOLD_CYCLES) hold_done <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      hold_cycles <= 0;
      if (!long_hold) hold_done <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [VAL_W-1:0] common_value(input int k);
    case (k)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0000_0001;
      5:       return 32'h0000_0005;
      6:       return 32'h0000_00A5;
      default: return 32'h5A5A_0F0F;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(input int pool_pct);
    if ($urandom_range(99) < pool_pct) return common_value($urandom_range(NUM_COMMON - 1));
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] position_for(input bit for_insert, input int fill,
                                                    input int bad_pct);
    int last_ok;
    logic [POS_W-1:0] pos;
    last_ok = for_insert ? fill : fill - 1;
    if (last_ok < 0 || $urandom_range(99) < bad_pct) pos = POS_W'($urandom_range(POS_MAX, fill));
    else pos = POS_W'($urandom_range(last_ok, 0));
    return pos;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int fill, input int target);
    int r;
    int grow_pct;
    r = $urandom_range(99);
    grow_pct = (fill < target) ? 45 : 20;
    if (r < 3) return OP_UNUSED;
    if (r < 3 + grow_pct) return ($urandom_range(1) == 0) ? OP_INSERT_AT : OP_INSERT_SORTED;
    r = $urandom_range(99);
    if (r < 18) return OP_ERASE;
    if (r < 30) return OP_REMOVE_ALL;
    if (r < 55) return OP_GET;
    if (r < 75) return OP_SET;
    return OP_FIND;
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    position <= pos;
    item_value <= val;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic random_request(input int target, input int pool_pct);
    logic [OP_W-1:0] op;
    op = pick_op(fill_level, target);
    send_request(op, position_for(op == OP_INSERT_AT, fill_level, 10), pick_value(pool_pct));
  endtask

  task automatic drain_wait();
    req_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin
        idle_pct = 0;
        stall_pct <= 0;
      end
      1: begin
        idle_pct = 50;
        stall_pct <= 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct <= 50;
      end
      default: begin
        idle_pct = 37;
        stall_pct <= 37;
      end
    endcase
  endtask

  task automatic fill_and_drain();
    int k;
    logic [OP_W-1:0] op;
    while (fill_level < CAPACITY) begin
      case ($urandom_range(9))
        0:       op = OP_GET;
        1:       op = OP_FIND;
        2, 3, 4: op = OP_INSERT_AT;
        default: op = OP_INSERT_SORTED;
      endcase
      send_request(op, position_for(op == OP_INSERT_AT, fill_level, 3), pick_value(90));
    end
    send_request(OP_INSERT_AT, POS_W'(CAPACITY), pick_value(0));
    send_request(OP_INSERT_AT, POS_W'(CAPACITY + 1), pick_value(0));
    send_request(OP_INSERT_SORTED, 0, pick_value(50));
    send_request(OP_GET, POS_W'(CAPACITY - 1), pick_value(0));
    send_request(OP_SET, POS_W'(CAPACITY - 1), pick_value(0));
    send_request(OP_GET, POS_W'(CAPACITY - 1), pick_value(0));
    send_request(OP_ERASE, POS_W'(CAPACITY), pick_value(0));
    send_request(OP_FIND, 0, pick_value(90));
    repeat (8) random_request(CAPACITY, 90);
    for (k = 0; k < NUM_COMMON; k++) begin
      send_request(OP_REMOVE_ALL, position_for(1'b0, fill_level, 50), common_value(k));
    end
    while (fill_level > 0) begin
      send_request(OP_ERASE, position_for(1'b0, fill_level, 5), pick_value(50));
    end
  endtask

  initial begin : stimulus
    int episode;
    int target;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table corners, then a short list with duplicates and extremes
    send_request(OP_GET, 0, 32'h0);
    send_request(OP_ERASE, 0, 32'h0);
    send_request(OP_SET, 0, 32'h1);
    send_request(OP_FIND, 0, 32'h5);
    send_request(OP_REMOVE_ALL, 0, 32'h5);
    send_request(OP_INSERT_AT, 1, 32'h1);
    send_request(OP_UNUSED, 9'h1FF, 32'hFFFF_FFFF);
    send_request(OP_INSERT_AT, 0, 32'hFFFF_FFFF);
    send_request(OP_INSERT_SORTED, 0, 32'h0);
    send_request(OP_INSERT_SORTED, 0, 32'hFFFF_FFFF);
    send_request(OP_INSERT_SORTED, 0, 32'h5);
    send_request(OP_INSERT_AT, 4, 32'h5);
    send_request(OP_INSERT_AT, 2, 32'h8000_0000);
    send_request(OP_FIND, 0, 32'h5);
    send_request(OP_GET, 5, 32'h0);
    send_request(OP_GET, 6, 32'h0);
    send_request(OP_SET, 0, 32'hAAAA_5555);
    send_request(OP_GET, 0, 32'h0);
    send_request(OP_REMOVE_ALL, 0, 32'hFFFF_FFFF);
    send_request(OP_REMOVE_ALL, 0, 32'h5);
    send_request(OP_ERASE, 1, 32'h0);
    send_request(OP_ERASE, 0, 32'h0);
    send_request(OP_INSERT_AT, 9'd256, 32'h0);
    send_request(OP_GET, 9'h1FF, 32'h0);
    send_request(OP_INSERT_SORTED, 0, 32'h5555_AAAA);
    drain_wait();

    // hold results back while requests keep coming
    long_hold <= 1'b1;
    repeat (6) random_request(8, 70);
    req_valid <= 1'b0;
    while (!hold_done) @(posedge clk);
    long_hold <= 1'b0;

    episode = 0;
    while (items_sent < ITEM_TOTAL) begin
      set_idling(episode % 4);
      if (episode == 4) begin
        fill_and_drain();
      end else begin
        target = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 0);
        repeat ($urandom_range(40, 20)) random_request(target, 60);
      end
      if (episode % 5 == 3) drain_wait();
      episode++;
    end

    drain_wait();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests under four idling mixes, a long result hold and a full table",
             items_sent);
    $display("%0d results compared, peak fill %0d of %0d, %0d inserts refused as full",
             results_checked, peak_fill, CAPACITY, full_rejects);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
